>>> rtl/core/slbs_pkg.sv
// Shared types and codes for the sorted-table lower-bound search.
package slbs_pkg;

    // Operation codes carried by s_operation
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Widths fixed by the input and result words
    localparam int KEY_W   = 32;
    localparam int IDX_W   = 10;
    localparam int LOW_W   = 12;
    localparam int HIGH_W  = 11;
    // Signed internal window bound: holds -1 .. 2047
    localparam int POS_W   = 13;

    // Sequencer to window datapath
    typedef struct packed {
        logic load;   // start a new window from the accepted word
        logic step;   // halve the window with the returned entry
    } win_ctrl_t;

    // Window datapath to sequencer
    typedef struct packed {
        logic              done;  // updated window holds no entry to probe
        logic [HIGH_W-1:0] pos;   // current upper bound, the answer when done
    } win_stat_t;

endpackage

>>> rtl/core/sorted_table_lower_bound_search.sv
// A search with n table probes posts its result after the probes and the emit state, which waits
// for a free result register (n = 0 for an empty window, n <= 11 at a depth of 1024).
// Throughput: one search at a time, one probe per cycle through the single read port of the
// table RAM; the next word can be taken in the same cycle that the result is posted.
// Reset clears the sequencer and the result valid; table contents are undefined until written.
module sorted_table_lower_bound_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic [slbs_pkg::IDX_W-1:0]          s_entry_index,
    input  logic signed [slbs_pkg::KEY_W-1:0]   s_word_value,
    input  logic signed [slbs_pkg::LOW_W-1:0]   s_window_low,
    input  logic [slbs_pkg::HIGH_W-1:0]         s_window_high,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [slbs_pkg::HIGH_W-1:0]         m_found_position
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    typedef enum logic [1:0] {
        IDLE,
        RUN,
        EMIT
    } state_t;

    state_t                           state_reg;
    logic                             m_valid_reg;
    logic [slbs_pkg::HIGH_W-1:0]      pos_reg;
    slbs_pkg::win_ctrl_t              ctrl;
    slbs_pkg::win_stat_t              stat;
    logic                             accept;
    logic                             ram_we, ram_re;
    logic [ADDR_W-1:0]                ram_waddr, ram_raddr;
    logic signed [slbs_pkg::KEY_W-1:0] ram_rdata;
    logic [31:0]                      idx_wide;
    logic                             slot_free;

    // Words are taken only between searches, so table writes never meet a probe
    assign s_ready   = (state_reg == IDLE);
    assign accept    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;

    assign idx_wide  = {{(32 - slbs_pkg::IDX_W){1'b0}}, s_entry_index};
    assign ram_we    = accept && (s_operation == slbs_pkg::OP_WRITE)
                       && (idx_wide < 32'(TABLE_DEPTH));
    assign ram_waddr = idx_wide[ADDR_W-1:0];

    assign ctrl.load = accept && (s_operation == slbs_pkg::OP_SEARCH);
    assign ctrl.step = (state_reg == RUN);

    slbs_ram #(
        .WIDTH (slbs_pkg::KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (s_word_value),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    slbs_window #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .key_in  (s_word_value),
        .low_in  (s_window_low),
        .high_in (s_window_high),
        .entry   (ram_rdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .stat    (stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            priority if (state_reg == EMIT && slot_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE: begin
                    if (ctrl.load) begin
                        state_reg <= stat.done ? EMIT : RUN;
                    end
                end
                RUN: begin
                    if (stat.done) begin
                        state_reg <= EMIT;
                    end
                end
                EMIT: begin
                    // hold until the result register is free
                    if (slot_free) begin
                        pos_reg   <= stat.pos;
                        state_reg <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_found_position = pos_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("table write collides with a probe");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == EMIT))
        else $error("result posted outside emit");

    // A waiting result is never overwritten by the next search
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == EMIT && m_valid_reg && !m_ready) |=> state_reg == EMIT)
        else $error("emit left while result stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == RUN) |-> $past(ram_re))
        else $error("step without a table read");
`endif

endmodule

>>> rtl/core/slbs_ram.sv
// Generic synchronous RAM with one write port and one registered read port.
module slbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/slbs_window.sv
// Search window datapath: bound clamping, halving step and probe address.
module slbs_window #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  slbs_pkg::win_ctrl_t              ctrl,
    input  logic signed [slbs_pkg::KEY_W-1:0]  key_in,
    input  logic signed [slbs_pkg::LOW_W-1:0]  low_in,
    input  logic [slbs_pkg::HIGH_W-1:0]        high_in,
    input  logic signed [slbs_pkg::KEY_W-1:0]  entry,
    output logic                             rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
    output slbs_pkg::win_stat_t              stat
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int POS_W  = slbs_pkg::POS_W;
    localparam int SUM_W  = POS_W + 1;

    logic signed [POS_W-1:0] lo_reg, hi_reg, mid_reg;
    logic signed [POS_W-1:0] lo_next, hi_next, mid_next;
    logic signed [POS_W-1:0] lo_clamp, hi_clamp;
    logic signed [slbs_pkg::KEY_W-1:0] key_reg;
    logic signed [SUM_W-1:0] sum, span;
    logic [31:0]             mid_wide;
    logic                    done_next;
    logic                    entry_less;

    // Clamp incoming bounds into [-1, TABLE_DEPTH]
    always_comb begin
        if (int'(low_in) < -1) begin
            lo_clamp = -POS_W'(1);
        end else if (int'(low_in) > TABLE_DEPTH) begin
            lo_clamp = POS_W'(TABLE_DEPTH);
        end else begin
            lo_clamp = POS_W'(low_in);
        end
        if (int'({1'b0, high_in}) > TABLE_DEPTH) begin
            hi_clamp = POS_W'(TABLE_DEPTH);
        end else begin
            hi_clamp = POS_W'({1'b0, high_in});
        end
    end

    assign entry_less = entry < key_reg;

    always_comb begin
        priority if (ctrl.load) begin
            lo_next = lo_clamp;
            hi_next = hi_clamp;
        end else if (ctrl.step) begin
            lo_next = entry_less ? mid_reg : lo_reg;
            hi_next = entry_less ? hi_reg : mid_reg;
        end else begin
            lo_next = lo_reg;
            hi_next = hi_reg;
        end
    end

    // Sum is at least zero whenever the window is open, so the shift halves it rounding down
    assign sum       = SUM_W'(lo_next) + SUM_W'(hi_next);
    assign span      = SUM_W'(hi_next) - SUM_W'(lo_next);
    assign mid_next  = POS_W'(sum >>> 1);
    assign done_next = span <= SUM_W'(1);
    assign mid_wide  = {{(32 - POS_W){1'b0}}, mid_next};

    assign rd_en     = (ctrl.load || ctrl.step) && !done_next;
    assign rd_addr   = mid_wide[ADDR_W-1:0];
    assign stat.done = done_next;
    assign stat.pos  = hi_reg[slbs_pkg::HIGH_W-1:0];

    always_ff @(posedge aclk) begin
        if (ctrl.load || ctrl.step) begin
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            mid_reg <= mid_next;
        end
        if (ctrl.load) begin
            key_reg <= key_in;
        end
    end

`ifndef SYNTHESIS
    // A halving step only happens on a window that still has a probe in it
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.step |-> (SUM_W'(hi_reg) - SUM_W'(lo_reg) > SUM_W'(1)))
        else $error("step on a closed window");

    // Each step strictly narrows the window
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.step |=> (hi_reg - lo_reg) < ($past(hi_reg) - $past(lo_reg)))
        else $error("window did not narrow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctrl.load && ctrl.step))
        else $error("load and step together");
`endif

endmodule
